// File: rtl/core/alle_pkg.sv
// Shared types and constants for the array linked list engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package alle_pkg;

  localparam int NODE_COUNT  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int CNT_W       = $clog2(NODE_COUNT + 1);
  localparam int WORD_W      = 32;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_SEARCH = 3'd2;
  localparam logic [2:0] OP_SIZE   = 3'd3;
  localparam logic [2:0] OP_DUMP   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef logic [NODE_W-1:0] idx_t;

  // tail marks the last node of a chain
  typedef struct packed {
    logic tail;
    idx_t nxt;
  } link_t;

  typedef struct packed {
    logic              link_re;
    idx_t              link_raddr;
    logic              link_we;
    idx_t              link_waddr;
    link_t             link_wdata;
    logic              cont_re;
    idx_t              cont_raddr;
    logic              cont_we;
    idx_t              cont_waddr;
    logic [WORD_W-1:0] cont_wdata;
  } store_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [4:0]        count;
    logic [WORD_W-1:0] word;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/alle_store.sv
// Node store: link memory and content memory, with registered synchronous reads.
// Depends on alle_pkg.
`default_nettype none

module alle_store import alle_pkg::*; (
  input  wire logic              clk,
  input  wire store_req_t        req,
  output link_t                  link_rdata,
  output logic [WORD_W-1:0]      cont_rdata
);

  link_t             link_mem [NODE_COUNT];
  logic [WORD_W-1:0] cont_mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    if (req.link_re) begin
      link_rdata <= link_mem[req.link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.cont_we) begin
      cont_mem[req.cont_waddr] <= req.cont_wdata;
    end
    if (req.cont_re) begin
      cont_rdata <= cont_mem[req.cont_raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/alle_out.sv
// Result output register; parts the sequencer from the downstream handshake.
// Depends on alle_pkg.
`default_nettype none

module alle_out import alle_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire res_t         res,
  output logic              slot_free,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        status,
  output logic [4:0]        count_or_place,
  output logic [WORD_W-1:0] word_out,
  output logic              last
);

  res_t held;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (push) begin
      held <= res;
    end
  end

  assign status         = held.status;
  assign count_or_place = held.count;
  assign word_out       = held.word;
  assign last           = held.last;

endmodule

`default_nettype wire

// File: rtl/core/alle_ctrl.sv
// Command sequencer: list and free-chain heads, link walks, clearing pass.
// Depends on alle_pkg; drives alle_store and alle_out.
`default_nettype none

module alle_ctrl import alle_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        opcode,
  input  wire logic [7:0]        position,
  input  wire logic [WORD_W-1:0] data_value,
  input  wire logic              cfg_wr_en,
  input  wire logic [4:0]        cfg_wr_data,
  output store_req_t             req,
  input  wire link_t             link_rdata,
  input  wire logic [WORD_W-1:0] cont_rdata,
  input  wire logic              slot_free,
  output logic                   push,
  output res_t                   res
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_INS_A, S_INS_B, S_INS_C, S_WALK, S_AFTER,
    S_REM2, S_REM3, S_SRCH, S_DUMP, S_EMIT
  } state_t;

  state_t            state;
  logic [2:0]        op_q;
  logic [7:0]        pos_q;
  logic [WORD_W-1:0] val_q;
  idx_t              cur;
  idx_t              a_q;
  link_t             fnext;
  logic [CNT_W-1:0]  steps;
  logic [CNT_W-1:0]  cnt;
  logic              first;
  logic [1:0]        res_status;
  logic [CNT_W-1:0]  res_count;
  idx_t              clr_idx;
  logic              clr_reply;
  idx_t              list_head;
  logic              list_empty;
  idx_t              free_head;
  logic              free_empty;
  logic [CNT_W-1:0]  size;
  logic [4:0]        cap;
  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  dump_len;
  logic              accept;
  logic              srch_more;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (cap == 5'd0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap) > NODE_COUNT) begin
      cap_eff = CNT_W'(NODE_COUNT);
    end else begin
      cap_eff = CNT_W'(cap);
    end
    if (32'(size) > MAX_RESULTS) begin
      dump_len = CNT_W'(MAX_RESULTS);
    end else begin
      dump_len = size;
    end
  end

  assign srch_more = (cont_rdata != val_q) && !link_rdata.tail &&
                     (32'(cnt) != NODE_COUNT);

  // memory requests
  always_comb begin
    req = '0;
    case (state)
      S_CLR: begin
        req.link_we    = 1'b1;
        req.link_waddr = clr_idx;
        if (CNT_W'(clr_idx) + CNT_W'(1) < cap_eff) begin
          req.link_wdata = '{tail: 1'b0, nxt: idx_t'(clr_idx + 1'b1)};
        end else begin
          req.link_wdata = '{tail: 1'b1, nxt: '0};
        end
      end
      S_INS_A: begin
        req.link_re    = 1'b1;
        req.link_raddr = free_head;
      end
      S_INS_B: begin
        req.cont_we    = 1'b1;
        req.cont_waddr = free_head;
        req.cont_wdata = val_q;
        if (pos_q == 8'd1) begin
          req.link_we    = 1'b1;
          req.link_waddr = free_head;
          req.link_wdata = '{tail: list_empty, nxt: list_head};
        end
      end
      S_WALK: begin
        if (first) begin
          req.link_re    = 1'b1;
          req.link_raddr = cur;
        end else if (steps != '0) begin
          req.link_re    = 1'b1;
          req.link_raddr = link_rdata.nxt;
        end
      end
      S_AFTER: begin
        if (op_q == OP_INSERT) begin
          req.link_we    = 1'b1;
          req.link_waddr = free_head;
          req.link_wdata = link_rdata;
        end else if (pos_q == 8'd1) begin
          req.link_we    = 1'b1;
          req.link_waddr = cur;
          req.link_wdata = '{tail: free_empty, nxt: free_head};
        end else begin
          req.link_re    = 1'b1;
          req.link_raddr = link_rdata.nxt;
        end
      end
      S_INS_C: begin
        req.link_we    = 1'b1;
        req.link_waddr = cur;
        req.link_wdata = '{tail: 1'b0, nxt: free_head};
      end
      S_REM2: begin
        req.link_we    = 1'b1;
        req.link_waddr = cur;
        req.link_wdata = link_rdata;
      end
      S_REM3: begin
        req.link_we    = 1'b1;
        req.link_waddr = a_q;
        req.link_wdata = '{tail: free_empty, nxt: free_head};
      end
      S_SRCH: begin
        if (first) begin
          req.link_re    = 1'b1;
          req.link_raddr = cur;
          req.cont_re    = 1'b1;
          req.cont_raddr = cur;
        end else if (srch_more) begin
          req.link_re    = 1'b1;
          req.link_raddr = link_rdata.nxt;
          req.cont_re    = 1'b1;
          req.cont_raddr = link_rdata.nxt;
        end
      end
      S_DUMP: begin
        if (first) begin
          req.link_re    = 1'b1;
          req.link_raddr = cur;
          req.cont_re    = 1'b1;
          req.cont_raddr = cur;
        end else if (slot_free && cnt != dump_len) begin
          req.link_re    = 1'b1;
          req.link_raddr = link_rdata.nxt;
          req.cont_re    = 1'b1;
          req.cont_raddr = link_rdata.nxt;
        end
      end
      default: begin
      end
    endcase
  end

  // result words
  always_comb begin
    push = 1'b0;
    res  = '{status: ST_OK, count: 5'd0, word: '0, last: 1'b1};
    if (state == S_EMIT && slot_free) begin
      push       = 1'b1;
      res.status = res_status;
      res.count  = 5'(res_count);
    end else if (state == S_DUMP && !first && slot_free) begin
      push     = 1'b1;
      res.word = cont_rdata;
      res.last = (cnt == dump_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_idx    <= '0;
      clr_reply  <= 1'b0;
      cap        <= 5'd16;
      list_head  <= '0;
      list_empty <= 1'b1;
      free_head  <= '0;
      free_empty <= 1'b0;
      size       <= '0;
      first      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == NODE_COUNT - 1) begin
            list_head  <= '0;
            list_empty <= 1'b1;
            free_head  <= '0;
            free_empty <= 1'b0;
            size       <= '0;
            res_status <= ST_OK;
            res_count  <= '0;
            state      <= clr_reply ? S_EMIT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q      <= opcode;
            pos_q     <= position;
            val_q     <= data_value;
            cur       <= list_head;
            first     <= 1'b1;
            cnt       <= CNT_W'(1);
            res_count <= '0;
            case (opcode)
              OP_INSERT: begin
                if (position == 8'd0 || 9'(position) > 9'(size) + 9'd1) begin
                  res_status <= ST_RANGE;
                  state      <= S_EMIT;
                end else if (free_empty) begin
                  res_status <= ST_FULL;
                  state      <= S_EMIT;
                end else begin
                  state <= S_INS_A;
                end
              end
              OP_REMOVE: begin
                if (position == 8'd0 || 9'(position) > 9'(size)) begin
                  res_status <= ST_RANGE;
                  state      <= S_EMIT;
                end else begin
                  steps <= (position == 8'd1) ? '0 : CNT_W'(position - 8'd2);
                  state <= S_WALK;
                end
              end
              OP_SEARCH: begin
                if (list_empty) begin
                  res_status <= ST_NOT_FOUND;
                  state      <= S_EMIT;
                end else begin
                  state <= S_SRCH;
                end
              end
              OP_SIZE: begin
                res_status <= ST_OK;
                res_count  <= size;
                state      <= S_EMIT;
              end
              OP_DUMP: begin
                if (size == '0) begin
                  res_status <= ST_OK;
                  state      <= S_EMIT;
                end else begin
                  state <= S_DUMP;
                end
              end
              OP_CLEAR: begin
                clr_idx   <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        S_INS_A: begin
          state <= S_INS_B;
        end
        S_INS_B: begin
          fnext <= link_rdata;
          if (pos_q == 8'd1) begin
            list_head  <= free_head;
            list_empty <= 1'b0;
            free_head  <= link_rdata.nxt;
            free_empty <= link_rdata.tail;
            size       <= size + 1'b1;
            res_status <= ST_OK;
            state      <= S_EMIT;
          end else begin
            steps <= CNT_W'(pos_q - 8'd2);
            first <= 1'b1;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (first) begin
            first <= 1'b0;
          end else if (steps != '0) begin
            cur   <= link_rdata.nxt;
            steps <= steps - 1'b1;
          end else begin
            state <= S_AFTER;
          end
        end
        S_AFTER: begin
          if (op_q == OP_INSERT) begin
            state <= S_INS_C;
          end else if (pos_q == 8'd1) begin
            list_head  <= link_rdata.nxt;
            list_empty <= link_rdata.tail;
            free_head  <= cur;
            free_empty <= 1'b0;
            size       <= size - 1'b1;
            res_status <= ST_OK;
            state      <= S_EMIT;
          end else begin
            a_q   <= link_rdata.nxt;
            state <= S_REM2;
          end
        end
        S_INS_C: begin
          free_head  <= fnext.nxt;
          free_empty <= fnext.tail;
          size       <= size + 1'b1;
          res_status <= ST_OK;
          state      <= S_EMIT;
        end
        S_REM2: begin
          state <= S_REM3;
        end
        S_REM3: begin
          free_head  <= a_q;
          free_empty <= 1'b0;
          size       <= size - 1'b1;
          res_status <= ST_OK;
          state      <= S_EMIT;
        end
        S_SRCH: begin
          if (first) begin
            first <= 1'b0;
          end else if (cont_rdata == val_q) begin
            res_status <= ST_OK;
            res_count  <= cnt;
            state      <= S_EMIT;
          end else if (!srch_more) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_EMIT;
          end else begin
            cur <= link_rdata.nxt;
            cnt <= cnt + 1'b1;
          end
        end
        S_DUMP: begin
          if (first) begin
            first <= 1'b0;
          end else if (slot_free) begin
            if (cnt == dump_len) begin
              state <= S_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    32'(size) <= NODE_COUNT) else $error("list size beyond node count");

  a_empty_size: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (list_empty == (size == '0)))
    else $error("empty flag disagrees with size");

  // unused opcodes are dropped and leave the sequencer idle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept && (opcode <= OP_CLEAR) |=> !in_ready)
    else $error("second word taken while busy");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> slot_free) else $error("result pushed into full slot");

endmodule

`default_nettype wire

// File: rtl/core/array_linked_list_engine_unit.sv
// Ordered list of 32-bit words in a 16-node store with a free chain. One
// command word is taken at a time; in_ready is high only while idle. Size,
// clear-reply and error words need no walk; search walks to the match;
// remove and insert past position 1 walk to the node before it; dump emits
// one word per node, stalling on out_ready. Each walk step costs one
// link-memory read. After reset and on every clear, a clearing pass over
// all 16 nodes rebuilds the free chain; no command word is taken meanwhile.
// A capacity write takes effect at the next clear. Depends on alle_pkg.
`default_nettype none

module array_linked_list_engine_unit import alle_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        opcode,
  input  wire logic [7:0]        position,
  input  wire logic [WORD_W-1:0] data_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic [4:0]             count_or_place,
  output logic [WORD_W-1:0]      word_out,
  output logic                   last,
  input  wire logic              cfg_wr_en,
  input  wire logic [4:0]        cfg_wr_data
);

  store_req_t        req;
  link_t             link_rdata;
  logic [WORD_W-1:0] cont_rdata;
  logic              slot_free;
  logic              push;
  res_t              res;

  alle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .position   (position),
    .data_value (data_value),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req),
    .link_rdata (link_rdata),
    .cont_rdata (cont_rdata),
    .slot_free  (slot_free),
    .push       (push),
    .res        (res)
  );

  alle_store u_store (
    .clk       (clk),
    .req       (req),
    .link_rdata(link_rdata),
    .cont_rdata(cont_rdata)
  );

  alle_out u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .res           (res),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .count_or_place(count_or_place),
    .word_out      (word_out),
    .last          (last)
  );

endmodule

`default_nettype wire
